FILE: hw/rtl/b32h_pkg.sv
// Types, constants and result-list helpers for the base32hex stream decoder.
// No dependencies; imported by the core, b32h_decode and b32h_serial.
package b32h_pkg;

    localparam int MAX_RES = 5;
    localparam int CNT_W   = 3;

    localparam logic [7:0] PAD_RESET = 8'd61;
    localparam logic [7:0] SEP_RESET = 8'd44;
    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_A    = 8'h41;
    localparam logic [7:0] CHAR_V    = 8'h56;
    localparam logic [7:0] ALPHA_OFS = 8'd10;

    localparam logic [1:0] REG_PAD = 2'd0;
    localparam logic [1:0] REG_SEP = 2'd1;

    typedef enum logic [1:0] {
        MODE_DECODING = 2'd0,
        MODE_PADDING  = 2'd1,
        MODE_DROPPING = 2'd2
    } mode_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_valid;
        logic       segment_end;
        logic       error;
    } res_t;

    typedef struct packed {
        res_t [MAX_RES-1:0] ent;
        logic [CNT_W-1:0]   n;
    } res_list_t;

    function automatic res_list_t push_res(res_list_t l, logic [7:0] b, logic bv,
                                           logic se, logic er);
        res_list_t r;
        r = l;
        if (r.n < CNT_W'(MAX_RES))
        begin
            r.ent[r.n].data_byte   = bv ? b : 8'd0;
            r.ent[r.n].byte_valid  = bv;
            r.ent[r.n].segment_end = se;
            r.ent[r.n].error       = er;
            r.n                    = r.n + CNT_W'(1);
        end
        return r;
    endfunction

    function automatic res_list_t close_seg(res_list_t l);
        res_list_t        r;
        logic [CNT_W-1:0] k;
        r = l;
        k = l.n - CNT_W'(1);
        if (l.n != '0 && !l.ent[k].segment_end)
            r.ent[k].segment_end = 1'b1;
        else
            r = push_res(l, 8'd0, 1'b0, 1'b1, 1'b0);
        return r;
    endfunction

    function automatic logic bad_count(logic [2:0] c);
        return (c == 3'd1) || (c == 3'd3) || (c == 3'd6);
    endfunction

    // partial group: data is low-aligned, 5 bits per symbol, tail bits dropped
    function automatic res_list_t flush_group(res_list_t l, logic [34:0] gb,
                                              logic [2:0] c);
        res_list_t r;
        r = l;
        case (c)
            3'd2:
            begin
                r = push_res(r, gb[9:2], 1'b1, 1'b0, 1'b0);
            end
            3'd4:
            begin
                r = push_res(r, gb[19:12], 1'b1, 1'b0, 1'b0);
                r = push_res(r, gb[11:4], 1'b1, 1'b0, 1'b0);
            end
            3'd5:
            begin
                r = push_res(r, gb[24:17], 1'b1, 1'b0, 1'b0);
                r = push_res(r, gb[16:9], 1'b1, 1'b0, 1'b0);
                r = push_res(r, gb[8:1], 1'b1, 1'b0, 1'b0);
            end
            3'd7:
            begin
                r = push_res(r, gb[34:27], 1'b1, 1'b0, 1'b0);
                r = push_res(r, gb[26:19], 1'b1, 1'b0, 1'b0);
                r = push_res(r, gb[18:11], 1'b1, 1'b0, 1'b0);
                r = push_res(r, gb[10:3], 1'b1, 1'b0, 1'b0);
            end
            3'd1, 3'd3, 3'd6:
            begin
                r = push_res(r, 8'd0, 1'b0, 1'b0, 1'b1);
            end
            default:
            begin
                r = l;
            end
        endcase
        return r;
    endfunction

endpackage

FILE: hw/rtl/base32hex_stream_decoder_core.sv
// Base32hex stream decoder, top level. A taken request is held in the input
// register and then decoded into the result buffer once that is free; one
// result per cycle while out_ready is high. With out_ready high, one character
// per cycle while each yields at most one result; a longer list holds the buffer.
// Reset (async, active low): empty group, decoding mode, pad '=' and
// separator ',', no request held. Depends on b32h_pkg, b32h_decode, b32h_serial.
module base32hex_stream_decoder_core
    import b32h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] symbol,
    input  logic       end_of_input,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       segment_end,
    output logic       error,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);

    logic [7:0] pad_char_reg, separator_char_reg;
    logic       in_valid_reg;
    logic [7:0] symbol_reg;
    logic       eoi_reg;
    logic       free, advance;
    res_list_t  results;

    assign cfg_ready = 1'b1;
    assign advance   = in_valid_reg && free;
    assign in_ready  = !in_valid_reg || free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pad_char_reg       <= PAD_RESET;
            separator_char_reg <= SEP_RESET;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_PAD: pad_char_reg       <= cfg_data;
                REG_SEP: separator_char_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            symbol_reg <= symbol;
            eoi_reg    <= end_of_input;
        end
    end

    b32h_decode u_decode (
        .clk            (clk),
        .rst_n          (rst_n),
        .advance        (advance),
        .symbol         (symbol_reg),
        .end_of_input   (eoi_reg),
        .pad_char       (pad_char_reg),
        .separator_char (separator_char_reg),
        .results        (results)
    );

    b32h_serial u_serial (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (advance),
        .results     (results),
        .free        (free),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .data_byte   (data_byte),
        .byte_valid  (byte_valid),
        .segment_end (segment_end),
        .error       (error),
        .last        (last)
    );

endmodule

FILE: hw/rtl/b32h_decode.sv
// Group state and result-list generation for one registered character.
// Depends on b32h_pkg.
module b32h_decode
    import b32h_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  logic [7:0]  symbol,
    input  logic        end_of_input,
    input  logic [7:0]  pad_char,
    input  logic [7:0]  separator_char,
    output res_list_t   results
);

    logic [34:0] group_bits_reg, group_bits_next;
    logic [2:0]  group_count_reg, group_count_next;
    mode_t       mode_reg, mode_next;

    logic        is_digit, is_alpha;
    logic [7:0]  sym_ofs;
    logic [4:0]  sym_val;

    assign is_digit = (symbol >= CHAR_ZERO) && (symbol <= CHAR_NINE);
    assign is_alpha = (symbol >= CHAR_A) && (symbol <= CHAR_V);
    assign sym_ofs  = is_digit ? (symbol - CHAR_ZERO) : (symbol - CHAR_A + ALPHA_OFS);
    assign sym_val  = sym_ofs[4:0];

    always_comb
    begin
        res_list_t l;
        mode_t     m;
        logic [34:0] gb;
        logic [2:0]  gc;
        logic        open;
        logic [39:0] full;
        l    = '0;
        m    = mode_reg;
        gb   = group_bits_reg;
        gc   = group_count_reg;
        open = 1'b1;
        full = {group_bits_reg, sym_val};

        if (symbol == separator_char)
        begin
            if (m == MODE_DECODING)
                l = flush_group(l, gb, gc);
            l    = close_seg(l);
            gb   = '0;
            gc   = '0;
            m    = MODE_DECODING;
            open = 1'b0;
        end
        else if (m == MODE_DROPPING)
        begin
            m = MODE_DROPPING;
        end
        else if (symbol == pad_char)
        begin
            if (m == MODE_DECODING)
            begin
                l  = flush_group(l, gb, gc);
                m  = bad_count(gc) ? MODE_DROPPING : MODE_PADDING;
                gb = '0;
                gc = '0;
            end
        end
        else if (!(is_digit || is_alpha))
        begin
            l  = push_res(l, 8'd0, 1'b0, 1'b0, 1'b1);
            gb = '0;
            gc = '0;
            m  = MODE_DROPPING;
        end
        else
        begin
            if (m == MODE_PADDING)
            begin
                l = close_seg(l);
                m = MODE_DECODING;
            end
            if (gc == 3'd7)
            begin
                l  = push_res(l, full[39:32], 1'b1, 1'b0, 1'b0);
                l  = push_res(l, full[31:24], 1'b1, 1'b0, 1'b0);
                l  = push_res(l, full[23:16], 1'b1, 1'b0, 1'b0);
                l  = push_res(l, full[15:8], 1'b1, 1'b0, 1'b0);
                l  = push_res(l, full[7:0], 1'b1, 1'b0, 1'b0);
                gb = '0;
                gc = '0;
            end
            else
            begin
                gb = {gb[29:0], sym_val};
                gc = gc + 3'd1;
            end
        end

        if (end_of_input && open)
        begin
            if (m == MODE_DECODING)
                l = flush_group(l, gb, gc);
            l  = close_seg(l);
            gb = '0;
            gc = '0;
            m  = MODE_DECODING;
        end

        results          = l;
        group_bits_next  = gb;
        group_count_next = gc;
        mode_next        = m;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            group_bits_reg  <= '0;
            group_count_reg <= '0;
            mode_reg        <= MODE_DECODING;
        end
        else if (advance)
        begin
            group_bits_reg  <= group_bits_next;
            group_count_reg <= group_count_next;
            mode_reg        <= mode_next;
        end
    end

endmodule

FILE: hw/rtl/b32h_serial.sv
// Result buffer: holds one character's result list and hands it out one
// result at a time. Depends on b32h_pkg.
module b32h_serial
    import b32h_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       load,
    input  res_list_t  results,
    output logic       free,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       byte_valid,
    output logic       segment_end,
    output logic       error,
    output logic       last
);

    res_t [MAX_RES-1:0] ent_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   idx_reg;
    logic               take, at_end;
    res_t               cur;

    assign cur         = ent_reg[idx_reg];
    assign at_end      = (idx_reg == cnt_reg - CNT_W'(1));
    assign out_valid   = (cnt_reg != '0);
    assign take        = out_valid && out_ready;
    assign free        = !out_valid || (take && at_end);
    assign data_byte   = cur.data_byte;
    assign byte_valid  = cur.byte_valid;
    assign segment_end = cur.segment_end;
    assign error       = cur.error;
    assign last        = at_end;

    always_ff @(posedge clk)
    begin
        if (load)
            ent_reg <= results.ent;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (load)
        begin
            cnt_reg <= results.n;
            idx_reg <= '0;
        end
        else if (take && at_end)
        begin
            cnt_reg <= '0;
            idx_reg <= '0;
        end
        else if (take)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

endmodule

FILE: hw/rtl/b32h_checker.sv
// Port-level checks for the base32hex stream decoder, bound to the top level.
// Depends on base32hex_stream_decoder_core port names only.
module b32h_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_byte,
    input logic       byte_valid,
    input logic       segment_end,
    input logic       error,
    input logic       last,
    input logic       cfg_ready
);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte) && $stable(last)
            && $stable(byte_valid) && $stable(segment_end) && $stable(error))
        else $error("result changed while stalled");

    a_byte_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && byte_valid |-> !error)
        else $error("byte result flagged as error");

    a_mark_only: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !byte_valid |-> data_byte == 8'd0 && (segment_end || error))
        else $error("empty result without a mark");

    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port not ready");

endmodule

bind base32hex_stream_decoder_core b32h_checker u_chk (.*);
